// ===== hdl/fvwf_pkg.sv =====
// Shared constants, types and register codes for the valid-window FIR filter.
`timescale 1ns / 1ps
package fvwf_pkg;

  localparam int MAX_TAPS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_W        = 16;
  localparam int FILT_W        = 36;
  localparam int TAP_COUNT_W   = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int COEF_PER_REG  = CFG_DATA_W / COEF_W;
  localparam int COEF_BANK_W   = 2 * CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH  = 2'd2;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  COEF_LOW_RST  = 64'd16384;
  localparam logic [CFG_DATA_W-1:0]  COEF_HIGH_RST = 64'd0;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  typedef struct packed {
    logic valid;
    logic status;
    logic done;
  } ctl_t;

endpackage

// ===== hdl/fvwf_in_if.sv =====
// Sample stream channel: valid, ready and one sample beat.
`timescale 1ns / 1ps
interface fvwf_in_if #(
  parameter int SAMPLE_BITS = fvwf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          set_end;

  modport source (output valid, output sample, output set_end, input ready);
  modport sink   (input valid, input sample, input set_end, output ready);
endinterface

// ===== hdl/fvwf_out_if.sv =====
// Result stream channel: valid, ready and one filter result beat.
`timescale 1ns / 1ps
interface fvwf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fvwf_pkg::FILT_W-1:0]  filtered;
  logic                                status;
  logic                                set_done;

  modport source (output valid, output filtered, output status, output set_done, input ready);
  modport sink   (input valid, input filtered, input status, input set_done, output ready);
endinterface

// ===== hdl/fvwf_cell.sv =====
// One window cell: holds a sample, passes it on and registers its product.
`timescale 1ns / 1ps
module fvwf_cell #(
  parameter int SAMPLE_BITS = fvwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [SAMPLE_BITS-1:0]       smp_in,
  input  logic signed [fvwf_pkg::COEF_W-1:0]  coef,
  output logic signed [SAMPLE_BITS-1:0]       smp_out,
  output logic signed [fvwf_pkg::FILT_W-1:0]  prod
);
  import fvwf_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_W;

  logic signed [PROD_W-1:0] full;
  logic signed [FILT_W-1:0] prod_next;

  assign full = smp_in * coef;

  generate
    if (PROD_W >= FILT_W) begin : g_trunc
      assign prod_next = full[FILT_W-1:0];
    end else begin : g_ext
      assign prod_next = FILT_W'(full);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_out <= '0;
      prod    <= '0;
    end else if (load) begin
      smp_out <= smp_in;
      prod    <= prod_next;
    end
  end

endmodule

// ===== hdl/fir_valid_window_filter.sv =====
// Top level of the valid-window FIR filter: cell row, adder tree and output register.
//
//   channel   dir  beat fields                     handshake
//   samples   in   sample, set_end                 valid / ready
//   results   out  filtered, status, set_done      valid / ready
//   cfg       in   cfg_index, cfg_data             cfg_we, no wait
//
// One sample per clock while samples.ready is high. A result passes the product
// register in each cell, one register per adder tree level and the output
// register. Stages advance into any empty slot, so bubbles close up behind a
// stalled result. Reset (rst, synchronous) clears the count, the valid flags
// and the config registers to their reset values.
`timescale 1ns / 1ps
module fir_valid_window_filter #(
  parameter int MAX_TAPS    = fvwf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fvwf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fvwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fvwf_pkg::CFG_DATA_W-1:0]    cfg_data,
  fvwf_in_if.sink                            samples,
  fvwf_out_if.source                         results
);
  import fvwf_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int LOG   = $clog2(MAX_TAPS);
  localparam int NPAD  = 1 << LOG;

  logic [TAP_COUNT_W-1:0] tap_count;
  logic [CFG_DATA_W-1:0]  coef_low;
  logic [CFG_DATA_W-1:0]  coef_high;
  logic [COEF_BANK_W-1:0] coef_bank;

  logic [CNT_W-1:0] taps;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_next;
  logic             emit;
  logic             accept;

  logic signed [COEF_W-1:0]      cell_coef [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] chain     [MAX_TAPS+1];
  logic signed [FILT_W-1:0]      lvl       [LOG+1][NPAD];
  ctl_t                          ctl       [LOG+1];
  logic                          en        [LOG+2];

  logic                     out_valid;
  logic signed [FILT_W-1:0] out_filtered;
  logic                     out_status;
  logic                     out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RST;
      coef_low  <= COEF_LOW_RST;
      coef_high <= COEF_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT: tap_count <= cfg_data[TAP_COUNT_W-1:0];
        REG_COEF_LOW:  coef_low  <= cfg_data;
        REG_COEF_HIGH: coef_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef_bank = {coef_high, coef_low};

  always_comb begin
    if (tap_count == '0) begin
      taps = CNT_W'(1);
    end else if (tap_count > TAP_COUNT_W'(MAX_TAPS)) begin
      taps = CNT_W'(MAX_TAPS);
    end else begin
      taps = CNT_W'(tap_count);
    end
  end

  // coefficient 0 weights the oldest sample in use
  always_comb begin
    for (int p = 0; p < MAX_TAPS; p++) begin
      cell_coef[p] = '0;
      for (int j = 0; j < MAX_TAPS; j++) begin
        if (CNT_W'(p) < taps && CNT_W'(j) == taps - CNT_W'(p + 1)) begin
          cell_coef[p] = coef_bank[COEF_W*j +: COEF_W];
        end
      end
    end
  end

  assign accept  = samples.valid && samples.ready;
  assign seen_next = (seen == CNT_W'(MAX_TAPS)) ? seen : seen + 1'b1;
  assign emit    = seen_next >= taps;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= samples.set_end ? '0 : seen_next;
    end
  end

  assign chain[0] = samples.sample;

  generate
    for (genvar p = 0; p < MAX_TAPS; p++) begin : g_cell
      fvwf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .load    (accept),
        .smp_in  (chain[p]),
        .coef    (cell_coef[p]),
        .smp_out (chain[p+1]),
        .prod    (lvl[0][p])
      );
    end
    for (genvar p = MAX_TAPS; p < NPAD; p++) begin : g_pad
      assign lvl[0][p] = '0;
    end

    for (genvar l = 0; l < LOG; l++) begin : g_lvl
      for (genvar i = 0; i < (NPAD >> (l + 1)); i++) begin : g_add
        always_ff @(posedge clk) begin
          if (en[l+1]) begin
            lvl[l+1][i] <= lvl[l][2*i] + lvl[l][2*i+1];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl[l+1].valid <= 1'b0;
          ctl[l+1].status <= STATUS_OK;
          ctl[l+1].done <= 1'b0;
        end else if (en[l+1]) begin
          ctl[l+1] <= ctl[l];
        end
      end
    end

    for (genvar s = 0; s <= LOG; s++) begin : g_en
      assign en[s] = !ctl[s].valid || en[s+1];
    end
  endgenerate

  assign en[LOG+1]     = !out_valid || results.ready;
  assign samples.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid  <= 1'b0;
      ctl[0].status <= STATUS_OK;
      ctl[0].done   <= 1'b0;
    end else if (en[0]) begin
      ctl[0].valid  <= accept && (emit || samples.set_end);
      ctl[0].status <= emit ? STATUS_OK : STATUS_TOO_LONG;
      ctl[0].done   <= samples.set_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[LOG+1]) begin
      out_valid <= ctl[LOG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LOG+1]) begin
      out_filtered <= (ctl[LOG].status == STATUS_TOO_LONG) ? '0 : lvl[LOG][0];
      out_status   <= ctl[LOG].status;
      out_done     <= ctl[LOG].done;
    end
  end

  assign results.valid    = out_valid;
  assign results.filtered = out_filtered;
  assign results.status   = out_status;
  assign results.set_done = out_done;

  a_too_long_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == STATUS_TOO_LONG |-> results.filtered == '0)
    else $error("too-long result carries a nonzero sum");

  a_too_long_done: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == STATUS_TOO_LONG |-> results.set_done)
    else $error("too-long result not marked as end of set");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen <= CNT_W'(MAX_TAPS))
    else $error("sample count beyond tap limit");

  a_seen_clear: assert property (@(posedge clk) disable iff (rst)
    accept && samples.set_end |=> seen == '0)
    else $error("sample count not cleared after end of set");

endmodule
